// ===== sv/cloth_stretch_energy_stress_macros.svh =====
// assertion helpers for the cloth stretch energy block
`ifndef CLOTH_STRETCH_ENERGY_STRESS_MACROS_SVH
`define CLOTH_STRETCH_ENERGY_STRESS_MACROS_SVH

// same-cycle implication, masked while in reset
`define CSES_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, also checked across reset
`define CSES_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/cses_pkg.sv =====
`timescale 1ns / 1ps
package cses_pkg;

  localparam int DATA_WIDTH_DEF = 24;
  localparam int FRAC_BITS      = 16;
  localparam int ENERGY_W       = 32;
  localparam int Q_DEPTH        = 4;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } cses_q_stat_t;

endpackage

// ===== sv/cses_if.sv =====
`timescale 1ns / 1ps
interface cses_in_if import cses_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] fu_x;
  logic signed [DW-1:0] fu_y;
  logic signed [DW-1:0] fu_z;
  logic signed [DW-1:0] fv_x;
  logic signed [DW-1:0] fv_y;
  logic signed [DW-1:0] fv_z;

  modport source (output valid, fu_x, fu_y, fu_z, fv_x, fv_y, fv_z, input ready);
  modport sink   (input valid, fu_x, fu_y, fu_z, fv_x, fv_y, fv_z, output ready);
endinterface

interface cses_out_if import cses_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
);
  logic                 valid;
  logic                 ready;
  logic [ENERGY_W-1:0]  energy;
  logic signed [DW-1:0] pu_x;
  logic signed [DW-1:0] pu_y;
  logic signed [DW-1:0] pu_z;
  logic signed [DW-1:0] pv_x;
  logic signed [DW-1:0] pv_y;
  logic signed [DW-1:0] pv_z;
  logic                 degenerate;

  modport source (output valid, energy, pu_x, pu_y, pu_z, pv_x, pv_y, pv_z, degenerate,
                  input ready);
  modport sink   (input valid, energy, pu_x, pu_y, pu_z, pv_x, pv_y, pv_z, degenerate,
                  output ready);
endinterface

// ===== sv/cses_front.sv =====
`timescale 1ns / 1ps
module cses_front import cses_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  cses_in_if.sink                in_if,
  input  cses_q_stat_t           q_stat,
  output logic                   push,
  output logic [6*(DW+1)-1:0]    item
);

  localparam int EW = DW + 1;

  logic [DW-1:0]       f [6];
  logic [6*EW-1:0]     item_nxt;
  logic [6*EW-1:0]     item_r;
  logic                item_vld_r;
  logic                accept;

  assign f[0] = in_if.fu_x;
  assign f[1] = in_if.fu_y;
  assign f[2] = in_if.fu_z;
  assign f[3] = in_if.fv_x;
  assign f[4] = in_if.fv_y;
  assign f[5] = in_if.fv_z;

  // split each entry into sign and magnitude
  always_comb begin
    logic [DW-1:0] neg_v;
    item_nxt = '0;
    for (int i = 0; i < 6; i++) begin
      neg_v = ~f[i] + 1'b1;
      item_nxt[i*EW +: EW] = {f[i][DW-1], f[i][DW-1] ? neg_v : f[i]};
    end
  end

  assign in_if.ready = !item_vld_r || !q_stat.full;
  assign accept      = in_if.valid && in_if.ready;
  assign push        = item_vld_r && !q_stat.full;
  assign item        = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (accept) begin
      item_vld_r <= 1'b1;
    end else if (push) begin
      item_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== sv/cses_queue.sv =====
`timescale 1ns / 1ps
module cses_queue import cses_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  input  logic         pop,
  output logic [W-1:0] dout,
  output cses_q_stat_t stat
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [W-1:0]    mem_r [DEPTH];
  logic [AW-1:0]   wr_ptr_r;
  logic [AW-1:0]   rd_ptr_r;
  logic [CNTW-1:0] cnt_r;

  always_comb begin
    stat.full  = (cnt_r == CNTW'(DEPTH));
    stat.empty = (cnt_r == '0);
  end

  assign dout = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== sv/cses_isqrt.sv =====
`timescale 1ns / 1ps
module cses_isqrt import cses_pkg::*; #(
  parameter int DW   = DATA_WIDTH_DEF,
  parameter int SB_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  logic [2*DW-1:0]   in_s,
  input  logic [SB_W-1:0]   in_sb,
  output logic              out_valid,
  output logic [DW-1:0]     out_root,
  output logic [SB_W-1:0]   out_sb
);

  localparam int RW = 2 * DW + 1;

  logic            vld_r  [DW];
  logic [DW-1:0]   root_r [DW];
  logic [SB_W-1:0] sb_r   [DW];
  logic [RW-1:0]   rem_r  [DW-1];

  // one root bit per stage, most significant first
  for (genvar k = 0; k < DW; k++) begin : g_stg
    localparam int I = DW - 1 - k;
    logic            vld_in;
    logic [RW-1:0]   rem_in;
    logic [DW-1:0]   root_in;
    logic [SB_W-1:0] sb_in;
    logic [RW-1:0]   one_sh;
    logic [RW-1:0]   t_val;
    logic [DW-1:0]   bit_sh;
    logic            ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = {1'b0, in_s};
      assign root_in = '0;
      assign sb_in   = in_sb;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign sb_in   = sb_r[k-1];
    end

    assign one_sh = {{(RW-1){1'b0}}, 1'b1} << (2 * I);
    assign bit_sh = {{(DW-1){1'b0}}, 1'b1} << I;
    assign t_val  = ({{(DW+1){1'b0}}, root_in} << (I + 1)) | one_sh;
    assign ge     = (rem_in >= t_val);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[k] <= ge ? (root_in | bit_sh) : root_in;
        sb_r[k]   <= sb_in;
      end
    end

    if (k < DW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rem_in - t_val) : rem_in;
        end
      end
    end
  end

  assign out_valid = vld_r[DW-1];
  assign out_root  = root_r[DW-1];
  assign out_sb    = sb_r[DW-1];

endmodule

// ===== sv/cses_div.sv =====
`timescale 1ns / 1ps
module cses_div import cses_pkg::*; #(
  parameter int DW   = DATA_WIDTH_DEF,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [DW-1:0]   in_len,
  input  logic [2*DW:0]   in_prod [3],
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output logic [DW+1:0]   out_q [3],
  output logic [2:0]      out_ovf,
  output logic [SB_W-1:0] out_sb
);

  // quotient of 4*prod/len, DW+2 bits, flagged when it would not fit
  localparam int NS = DW + 3;

  logic            vld_r [NS];
  logic [2:0]      ovf_r [NS];
  logic [SB_W-1:0] sb_r  [NS];
  logic [DW+1:0]   q_r   [NS][3];
  logic [DW-1:0]   len_r [NS-1];
  logic [DW-1:0]   rem_r [NS-1][3];
  logic [DW+1:0]   lo_r  [NS-1][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0]  <= in_sb;
      len_r[0] <= in_len;
      for (int l = 0; l < 3; l++) begin
        ovf_r[0][l] <= (in_prod[l][2*DW:DW] >= {1'b0, in_len});
        rem_r[0][l] <= in_prod[l][2*DW-1:DW];
        lo_r[0][l]  <= {in_prod[l][DW-1:0], 2'b00};
        q_r[0][l]   <= '0;
      end
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_stp
    logic [DW:0] cand [3];
    logic [DW:0] diff [3];
    logic [2:0]  ge;

    always_comb begin
      for (int l = 0; l < 3; l++) begin
        cand[l] = {rem_r[k-1][l], lo_r[k-1][l][DW+1]};
        diff[l] = cand[l] - {1'b0, len_r[k-1]};
        ge[l]   = (cand[l] >= {1'b0, len_r[k-1]});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[k] <= ovf_r[k-1];
        sb_r[k]  <= sb_r[k-1];
        for (int l = 0; l < 3; l++) begin
          q_r[k][l] <= {q_r[k-1][l][DW:0], ge[l]};
        end
      end
    end

    if (k < NS - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          len_r[k] <= len_r[k-1];
          for (int l = 0; l < 3; l++) begin
            rem_r[k][l] <= ge[l] ? diff[l][DW-1:0] : cand[l][DW-1:0];
            lo_r[k][l]  <= lo_r[k-1][l] << 1;
          end
        end
      end
    end
  end

  assign out_valid = vld_r[NS-1];
  assign out_ovf   = ovf_r[NS-1];
  assign out_sb    = sb_r[NS-1];
  assign out_q     = q_r[NS-1];

endmodule

// ===== sv/cses_back.sv =====
`timescale 1ns / 1ps
module cses_back import cses_pkg::*; #(
  parameter int DW = DATA_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  cses_q_stat_t        q_stat,
  input  logic [6*(DW+1)-1:0] q_data,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ENERGY_W-1:0] energy,
  output logic [DW-1:0]       pu [3],
  output logic [DW-1:0]       pv [3],
  output logic                degenerate
);

  localparam int EW    = DW + 1;
  localparam int CW    = 3 * EW;
  localparam int ESW   = 2 * DW + 3;
  localparam int USB_W = ENERGY_W + 5;
  localparam int VSB_W = 5;
  localparam int ONE_Q = 1 << FRAC_BITS;
  localparam int HALF  = 1 << (FRAC_BITS - 1);

  logic adv;

  // squares
  logic            sq_vld_r;
  logic [2*DW-1:0] sq_r [6];
  logic [EW-1:0]   el_r [6];
  // column sums
  logic            s_vld_r;
  logic [2*DW-1:0] s_r   [2];
  logic [CW-1:0]   cel_r [2];
  // roots
  logic            rt_vld [2];
  logic [DW-1:0]   root   [2];
  logic [CW-1:0]   rsb    [2];
  // stretch and products
  logic            p_vld_r;
  logic [DW-1:0]   len_r   [2];
  logic            zero_r  [2];
  logic            dneg_r  [2];
  logic [2*DW+1:0] d2_r    [2];
  logic [2*DW:0]   prod_r  [2][3];
  logic [2:0]      eneg_r  [2];
  logic [DW:0]     d_c     [2];
  logic [DW:0]     dm_c    [2];
  // energy
  logic [ESW-1:0]      esum;
  logic [ESW-1:0]      eshift;
  logic [ENERGY_W-1:0] energy_c;
  // divider
  logic             dv_vld [2];
  logic [DW+1:0]    dq     [2][3];
  logic [2:0]       dovf   [2];
  logic [USB_W-1:0] usb_out;
  logic [VSB_W-1:0] vsb_out;
  // output register
  logic                out_valid_r;
  logic [ENERGY_W-1:0] energy_r;
  logic [DW-1:0]       pu_r [3];
  logic [DW-1:0]       pv_r [3];
  logic                degen_r;

  assign adv   = !out_valid_r || out_ready;
  assign q_pop = adv && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r <= 1'b0;
      s_vld_r  <= 1'b0;
      p_vld_r  <= 1'b0;
    end else if (adv) begin
      sq_vld_r <= q_pop;
      s_vld_r  <= sq_vld_r;
      p_vld_r  <= rt_vld[0] && rt_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 6; i++) begin
        el_r[i] <= q_data[i*EW +: EW];
        sq_r[i] <= q_data[i*EW +: DW] * q_data[i*EW +: DW];
      end
      for (int c = 0; c < 2; c++) begin
        s_r[c]   <= sq_r[3*c] + sq_r[3*c+1] + sq_r[3*c+2];
        cel_r[c] <= {el_r[3*c+2], el_r[3*c+1], el_r[3*c]};
      end
    end
  end

  for (genvar c = 0; c < 2; c++) begin : g_col
    cses_isqrt #(.DW(DW), .SB_W(CW)) u_isqrt (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (adv),
      .in_valid  (s_vld_r),
      .in_s      (s_r[c]),
      .in_sb     (cel_r[c]),
      .out_valid (rt_vld[c]),
      .out_root  (root[c]),
      .out_sb    (rsb[c])
    );
  end

  // signed stretch (length - 1.0) and its magnitude
  always_comb begin
    for (int c = 0; c < 2; c++) begin
      d_c[c]  = {1'b0, root[c]} - EW'(ONE_Q);
      dm_c[c] = d_c[c][DW] ? (~d_c[c] + 1'b1) : d_c[c];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 2; c++) begin
        len_r[c]  <= root[c];
        zero_r[c] <= (root[c] == '0);
        dneg_r[c] <= d_c[c][DW];
        d2_r[c]   <= dm_c[c] * dm_c[c];
        for (int k = 0; k < 3; k++) begin
          eneg_r[c][k] <= rsb[c][k*EW + DW];
          prod_r[c][k] <= rsb[c][k*EW +: DW] * dm_c[c];
        end
      end
    end
  end

  // energy, rounded half up to q16.16 and clamped
  assign esum   = ESW'(d2_r[0]) + ESW'(d2_r[1]) + ESW'(HALF);
  assign eshift = esum >> FRAC_BITS;
  assign energy_c = (eshift > {{(ESW-ENERGY_W){1'b0}}, {ENERGY_W{1'b1}}}) ?
                    {ENERGY_W{1'b1}} : eshift[ENERGY_W-1:0];

  cses_div #(.DW(DW), .SB_W(USB_W)) u_div_u (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p_vld_r),
    .in_len    (len_r[0]),
    .in_prod   (prod_r[0]),
    .in_sb     ({energy_c, zero_r[0], dneg_r[0], eneg_r[0]}),
    .out_valid (dv_vld[0]),
    .out_q     (dq[0]),
    .out_ovf   (dovf[0]),
    .out_sb    (usb_out)
  );

  cses_div #(.DW(DW), .SB_W(VSB_W)) u_div_v (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p_vld_r),
    .in_len    (len_r[1]),
    .in_prod   (prod_r[1]),
    .in_sb     ({zero_r[1], dneg_r[1], eneg_r[1]}),
    .out_valid (dv_vld[1]),
    .out_q     (dq[1]),
    .out_ovf   (dovf[1]),
    .out_sb    (vsb_out)
  );

  // round 4*prod/len to nearest of 2*prod/len, clamp, apply sign; zero for a zero-length column
  function automatic logic [DW-1:0] stress_fin(input logic [DW+1:0] q, input logic ovf,
                                               input logic neg, input logic zero);
    logic [DW+2:0] r;
    logic [DW-1:0] cap;
    logic [DW-1:0] m;
    r   = ({1'b0, q} + 1'b1) >> 1;
    cap = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    m   = (ovf || (r > {3'b000, cap})) ? cap : r[DW-1:0];
    if (zero) begin
      return '0;
    end
    return neg ? (~m + 1'b1) : m;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_vld[0] && dv_vld[1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      energy_r <= usb_out[USB_W-1:5];
      degen_r  <= usb_out[4] || vsb_out[4];
      for (int k = 0; k < 3; k++) begin
        pu_r[k] <= stress_fin(dq[0][k], dovf[0][k], usb_out[k] ^ usb_out[3], usb_out[4]);
        pv_r[k] <= stress_fin(dq[1][k], dovf[1][k], vsb_out[k] ^ vsb_out[3], vsb_out[4]);
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign energy     = energy_r;
  assign pu         = pu_r;
  assign pv         = pv_r;
  assign degenerate = degen_r;

endmodule

// ===== sv/cloth_stretch_energy_stress.sv =====
`timescale 1ns / 1ps
// cloth stretch energy and first piola-kirchhoff stress for one 3x2 gradient per word
// input channel in_if: six signed q8.16 entries, column u then column v
// result channel out_if: energy (unsigned q16.16, clamped), six stress entries
//   (signed q8.16, clamped) and a degenerate flag for a zero-length column
// one result word per input word, in order
// throughput: one word per clock when the receiver keeps ready high
// most of the back pipeline is the bit-per-stage square root
//   (DATA_WIDTH stages) and the bit-per-stage stress divider (DATA_WIDTH + 3)
// the front registers the word and splits sign from magnitude, a four-word
//   queue decouples it from the back pipeline that does the arithmetic
// when the receiver stalls the back pipeline holds in place, the queue fills,
//   and only then does in_if.ready drop
// synchronous active-low reset empties front, queue and pipeline; no result
//   is pending after reset
`include "cloth_stretch_energy_stress_macros.svh"
module cloth_stretch_energy_stress import cses_pkg::*; #(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input logic         clk,
  input logic         rst_n,
  cses_in_if.sink     in_if,
  cses_out_if.source  out_if
);

  localparam int EW = DATA_WIDTH + 1;

  cses_q_stat_t          q_stat;
  logic                  q_push;
  logic                  q_pop;
  logic [6*EW-1:0]       q_din;
  logic [6*EW-1:0]       q_dout;
  logic [DATA_WIDTH-1:0] pu [3];
  logic [DATA_WIDTH-1:0] pv [3];

  // front: take the word, split sign and magnitude
  cses_front #(.DW(DATA_WIDTH)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .push   (q_push),
    .item   (q_din)
  );

  // short queue between front and back
  cses_queue #(.W(6*EW), .DEPTH(Q_DEPTH)) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .stat  (q_stat)
  );

  // back: squares, roots, products, division, output register
  cses_back #(.DW(DATA_WIDTH)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_data     (q_dout),
    .q_pop      (q_pop),
    .out_valid  (out_if.valid),
    .out_ready  (out_if.ready),
    .energy     (out_if.energy),
    .pu         (pu),
    .pv         (pv),
    .degenerate (out_if.degenerate)
  );

  assign out_if.pu_x = pu[0];
  assign out_if.pu_y = pu[1];
  assign out_if.pu_z = pu[2];
  assign out_if.pv_x = pv[0];
  assign out_if.pv_y = pv[1];
  assign out_if.pv_z = pv[2];

  // a degenerate word carries at least 1.0 of energy from the zero column
  `CSES_ASSERT_IMP(a_degen_energy, out_if.valid && out_if.degenerate, out_if.energy >= 32'h0001_0000, "degenerate word with energy below one")
  // a degenerate word has at least one column of zero stress
  `CSES_ASSERT_IMP(a_degen_zero, out_if.valid && out_if.degenerate, (pu[0] == '0 && pu[1] == '0 && pu[2] == '0) || (pv[0] == '0 && pv[1] == '0 && pv[2] == '0), "degenerate word without a zero stress column")
  // nothing is offered right after reset
  `CSES_ASSERT_NXT(a_rst_empty, !rst_n, !out_if.valid, "result valid after reset")

endmodule
